/* sv/calr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the checksum line receiver.
// Used by calr_ctrl, calr_dp and the top level; depends on nothing.

package calr_pkg;

	// Longest line; a line ends on LF or when this many bytes are held
	localparam int LINE_MAX = 64;
	localparam int IDX_W    = $clog2(LINE_MAX);
	localparam int FILL_W   = $clog2(LINE_MAX + 1);
	// Two line buffers, one per bank: collecting and held
	localparam int ADDR_W   = IDX_W + 1;
	localparam int MEM_DEPTH = 2 * (2 ** IDX_W);

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_QM = 8'h3F;

	// Lengths of the two protocol lines
	localparam int ACK_LEN  = 4;
	localparam int CONN_LEN = 5;

	// Source of the byte loaded into the output register
	typedef enum logic [2:0] {
		SEL_SUM = 3'b001,
		SEL_ACK = 3'b010,
		SEL_DLV = 3'b100
	} out_sel_t;

	// Link phase
	typedef enum logic [2:0] {
		PH_WAIT = 3'b001,
		PH_CONN = 3'b010,
		PH_HELD = 3'b100
	} phase_t;

	// Controller to datapath
	typedef struct packed {
		logic     load_byte;
		logic     accept_char;
		logic     hold;
		logic     retry_clr;
		logic     retry_inc;
		logic     idx_clr;
		logic     idx_inc;
		logic     out_load;
		out_sel_t out_sel;
	} calr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic char_ok;
		logic line_end;
		logic ok_match;
		logic ko_match;
		logic slot_free;
		logic ack_last;
		logic dlv_last;
	} calr_sts_t;

	// "OK" CR LF, one byte by position
	function automatic logic [7:0] ack_at(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0:    c = 8'h4F;
			2'd1:    c = 8'h4B;
			2'd2:    c = CH_CR;
			default: c = CH_LF;
		endcase
		return c;
	endfunction

	// "KO?" CR LF, one byte by position
	function automatic logic [7:0] conn_at(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = 8'h4B;
			3'd1:    c = 8'h4F;
			3'd2:    c = CH_QM;
			3'd3:    c = CH_CR;
			3'd4:    c = CH_LF;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Character filter: digits and capitals anywhere, CR/LF/'?' not first
	function automatic logic char_ok(input logic [7:0] c, input logic first);
		logic ok;
		ok = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			(!first && ((c == CH_LF) || (c == CH_CR) || (c == CH_QM)));
		return ok;
	endfunction

endpackage

/* sv/checksum_acked_line_receiver_unit.sv */
`timescale 1ns / 1ps
// Top level of the checksum acknowledged line receiver.
// Joins calr_ctrl and calr_dp; depends on calr_pkg.

// Takes one received byte per transfer and replies through one output channel.
// Each byte is accepted, then evaluated; a dropped byte or one that
// does not end a line gives no result. A checksum answer, the
// connect answer and delivery of a held line follow in their own states;
// delivery reads each byte from the line buffer memory through its
// registered read port before it is loaded into the output register. Any
// stall on the output side holds these answers. The next byte is taken
// while the last result still waits in the output register. Held lines are
// kept by swapping between two buffer banks, so no copy pass is needed.

module checksum_acked_line_receiver_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic [7:0] retry_count
);

	calr_pkg::calr_cmd_t cmd;
	calr_pkg::calr_sts_t sts;

	// Sequencer
	calr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Buffers and output register
	calr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.out_last    (out_last),
		.retry_count (retry_count)
	);

endmodule

/* sv/calr_dp.sv */
`timescale 1ns / 1ps
// Datapath: byte register, line buffers, fill and sum, pattern match flags,
// retry count and output register. Depends on calr_pkg.

module calr_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  calr_pkg::calr_cmd_t cmd,
	output calr_pkg::calr_sts_t sts,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_kind,
	output logic [7:0]          out_byte,
	output logic                out_last,
	output logic [7:0]          retry_count
);

	logic [7:0]                      byte_q;
	logic [calr_pkg::IDX_W-1:0]      fill_q;
	logic [7:0]                      sum_q;
	logic [7:0]                      chk_q;
	logic                            ok_q;
	logic                            ko_q;
	logic                            held_bank_q;
	logic [calr_pkg::FILL_W-1:0]     held_len_q;
	logic [7:0]                      retries_q;
	logic [calr_pkg::IDX_W-1:0]      idx_q;
	logic [7:0]                      rd_data_q;
	logic                            out_valid_q;
	logic                            out_kind_q;
	logic [7:0]                      out_byte_q;
	logic                            out_last_q;
	logic [7:0]                      out_retry_q;
	logic [7:0]                      mem [0:calr_pkg::MEM_DEPTH-1];

	logic                            ok_next;
	logic                            ko_next;
	logic [7:0]                      sum_next;
	logic [calr_pkg::ADDR_W-1:0]     wr_addr;
	logic [calr_pkg::ADDR_W-1:0]     rd_addr;
	logic [calr_pkg::FILL_W-1:0]     idx_plus1;

	// Pattern tracking and status
	always_comb begin
		sum_next = sum_q + byte_q;
		ok_next  = ((fill_q == '0) || ok_q) &&
			(fill_q < calr_pkg::IDX_W'(calr_pkg::ACK_LEN)) &&
			(byte_q == calr_pkg::ack_at(fill_q[1:0]));
		ko_next  = ((fill_q == '0) || ko_q) &&
			(fill_q < calr_pkg::IDX_W'(calr_pkg::CONN_LEN)) &&
			(byte_q == calr_pkg::conn_at(fill_q[2:0]));
		idx_plus1 = calr_pkg::FILL_W'(idx_q) + calr_pkg::FILL_W'(1);

		sts.char_ok   = calr_pkg::char_ok(byte_q, fill_q == '0);
		sts.line_end  = (byte_q == calr_pkg::CH_LF) ||
			(fill_q == calr_pkg::IDX_W'(calr_pkg::LINE_MAX - 1));
		sts.ok_match  = ok_next && (fill_q == calr_pkg::IDX_W'(calr_pkg::ACK_LEN - 1));
		sts.ko_match  = ko_next && (fill_q == calr_pkg::IDX_W'(calr_pkg::CONN_LEN - 1));
		sts.slot_free = !out_valid_q || out_ready;
		sts.ack_last  = (idx_q == calr_pkg::IDX_W'(calr_pkg::ACK_LEN - 1));
		sts.dlv_last  = (idx_plus1 == held_len_q);
	end

	// Collecting bank is the one not held
	assign wr_addr = {~held_bank_q, fill_q};
	assign rd_addr = {held_bank_q, idx_q};

	// Line buffers, registered read
	always_ff @(posedge clk) begin
		if (cmd.accept_char)
			mem[wr_addr] <= byte_q;
		rd_data_q <= mem[rd_addr];
	end

	// Byte register
	always_ff @(posedge clk) begin
		if (cmd.load_byte)
			byte_q <= rx_byte;
	end

	// Line collection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
			ok_q   <= 1'b0;
			ko_q   <= 1'b0;
		end else if (cmd.accept_char) begin
			ok_q <= ok_next;
			ko_q <= ko_next;
			if (sts.line_end) begin
				fill_q <= '0;
				sum_q  <= '0;
			end else begin
				fill_q <= fill_q + calr_pkg::IDX_W'(1);
				sum_q  <= sum_next;
			end
		end
	end

	// Checksum of the line just ended
	always_ff @(posedge clk) begin
		if (cmd.accept_char && sts.line_end)
			chk_q <= sum_next;
	end

	// Held line: swap banks instead of copying
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bank_q <= 1'b0;
			held_len_q  <= '0;
			retries_q   <= '0;
		end else begin
			if (cmd.hold) begin
				held_bank_q <= ~held_bank_q;
				held_len_q  <= calr_pkg::FILL_W'(fill_q) + calr_pkg::FILL_W'(1);
			end
			if (cmd.retry_clr)
				retries_q <= '0;
			else if (cmd.retry_inc && (retries_q != 8'hFF))
				retries_q <= retries_q + 8'd1;
		end
	end

	// Emission index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (cmd.idx_clr)
			idx_q <= '0;
		else if (cmd.idx_inc)
			idx_q <= idx_q + calr_pkg::IDX_W'(1);
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_sel)
				calr_pkg::SEL_SUM: begin
					out_kind_q  <= 1'b0;
					out_byte_q  <= chk_q;
					out_last_q  <= 1'b1;
					out_retry_q <= 8'd0;
				end
				calr_pkg::SEL_ACK: begin
					out_kind_q  <= 1'b0;
					out_byte_q  <= calr_pkg::ack_at(idx_q[1:0]);
					out_last_q  <= sts.ack_last;
					out_retry_q <= 8'd0;
				end
				default: begin
					out_kind_q  <= 1'b1;
					out_byte_q  <= rd_data_q;
					out_last_q  <= sts.dlv_last;
					out_retry_q <= retries_q;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_byte    = out_byte_q;
	assign out_last    = out_last_q;
	assign retry_count = out_retry_q;

endmodule

/* sv/calr_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequencing state machine and link phase.
// Drives datapath commands from its status; depends on calr_pkg.

module calr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  calr_pkg::calr_sts_t sts,
	output calr_pkg::calr_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EVAL = 6'b000010,
		S_SUM  = 6'b000100,
		S_ACK  = 6'b001000,
		S_DRD  = 6'b010000,
		S_DOUT = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	calr_pkg::phase_t  phase_q, phase_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		cmd.out_sel = calr_pkg::SEL_SUM;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_byte = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_IDLE;
				if (sts.char_ok) begin
					cmd.accept_char = 1'b1;
					if (sts.line_end) begin
						case (phase_q)
							calr_pkg::PH_CONN: begin
								cmd.hold      = 1'b1;
								cmd.retry_clr = 1'b1;
								phase_d = calr_pkg::PH_HELD;
								state_d = S_SUM;
							end
							calr_pkg::PH_HELD: begin
								if (sts.ok_match) begin
									cmd.idx_clr = 1'b1;
									state_d = S_DRD;
								end else begin
									cmd.hold      = 1'b1;
									cmd.retry_inc = 1'b1;
									state_d = S_SUM;
								end
							end
							default: begin
								if (sts.ko_match) begin
									cmd.idx_clr = 1'b1;
									phase_d = calr_pkg::PH_CONN;
									state_d = S_ACK;
								end
							end
						endcase
					end
				end
			end
			S_SUM: begin
				cmd.out_sel = calr_pkg::SEL_SUM;
				if (sts.slot_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ACK: begin
				cmd.out_sel = calr_pkg::SEL_ACK;
				if (sts.slot_free) begin
					cmd.out_load = 1'b1;
					cmd.idx_inc  = 1'b1;
					if (sts.ack_last)
						state_d = S_IDLE;
				end
			end
			S_DRD: begin
				// read of the held byte is in flight
				state_d = S_DOUT;
			end
			S_DOUT: begin
				cmd.out_sel = calr_pkg::SEL_DLV;
				if (sts.slot_free) begin
					cmd.out_load = 1'b1;
					cmd.idx_inc  = 1'b1;
					if (sts.dlv_last) begin
						phase_d = calr_pkg::PH_CONN;
						state_d = S_IDLE;
					end else begin
						state_d = S_DRD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= calr_pkg::PH_WAIT;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

/* bench/checksum_acked_line_receiver_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for checksum_acked_line_receiver_unit: byte stimulus, line predictor
// and reply scoreboard. Depends on calr_pkg and the receiver RTL only.

module checksum_acked_line_receiver_unit_tb;

	localparam int WATCH_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 32;
	localparam int ITEM_TARGET  = 420;
	localparam int CALM_TAIL    = 80;

	// Reply kinds on out_kind
	localparam bit KIND_TX   = 1'b0;
	localparam bit KIND_LINE = 1'b1;

	localparam logic [7:0] CH_O    = "O";
	localparam logic [7:0] CH_K    = "K";
	localparam logic [7:0] CH_X    = "X";
	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [7:0] CH_A    = "A";
	localparam logic [7:0] CH_LOWA = "a";

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       out_kind;
	logic [7:0] out_byte;
	logic       out_last;
	logic [7:0] retry_count;

	bit idle_on = 1'b1;
	int bytes_sent;

	checksum_acked_line_receiver_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.out_last    (out_last),
		.retry_count (retry_count)
	);

	typedef struct {
		bit       kind;
		bit [7:0] data;
		bit       last;
		bit [7:0] retries;
	} reply_t;

	// Line predictor plus queue of replies it expects from the block
	class line_reply_board;
		calr_pkg::phase_t link_phase;
		bit [7:0]   collect_buf[calr_pkg::LINE_MAX];
		int         collect_len;
		bit [7:0]   collect_sum;
		bit [7:0]   held_buf[calr_pkg::LINE_MAX];
		int         held_len;
		bit [7:0]   retry_ctr;
		bit [7:0]   ack_seq[$];
		bit [7:0]   conn_seq[$];
		reply_t     expected_replies[$];
		int         kept_bytes;
		int         replies_seen;
		int         faults;
		int         connects;
		int         checksums;
		int         deliveries;
		int         peak_retry;

		function new();
			link_phase   = calr_pkg::PH_WAIT;
			collect_len  = 0;
			collect_sum  = 8'h00;
			held_len     = 0;
			retry_ctr    = 8'h00;
			ack_seq      = '{CH_O, CH_K, calr_pkg::CH_CR, calr_pkg::CH_LF};
			conn_seq     = '{CH_K, CH_O, calr_pkg::CH_QM, calr_pkg::CH_CR, calr_pkg::CH_LF};
			kept_bytes   = 0;
			replies_seen = 0;
			faults       = 0;
			connects     = 0;
			checksums    = 0;
			deliveries   = 0;
			peak_retry   = 0;
		endfunction

		// Digits and capitals always; CR, LF and '?' only past the first slot
		function bit passes_filter(bit [7:0] c);
			bit alnum;
			alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z");
			return alnum || (collect_len != 0 && (c == calr_pkg::CH_LF ||
				c == calr_pkg::CH_CR || c == calr_pkg::CH_QM));
		endfunction

		function bit line_equals(bit [7:0] pat[$]);
			if (collect_len != pat.size())
				return 1'b0;
			foreach (pat[i])
				if (collect_buf[i] != pat[i])
					return 1'b0;
			return 1'b1;
		endfunction

		function void push_reply(bit kind, bit [7:0] data, bit last, bit [7:0] rc);
			reply_t r;
			r.kind    = kind;
			r.data    = data;
			r.last    = last;
			r.retries = rc;
			expected_replies.push_back(r);
		endfunction

		function void keep_line();
			for (int i = 0; i < collect_len; i++)
				held_buf[i] = collect_buf[i];
			held_len = collect_len;
		endfunction

		// Note one accepted byte; returns 1 when the filter keeps it
		function bit take_byte(bit [7:0] c);
			bit [7:0] total;
			if (!passes_filter(c) || collect_len >= calr_pkg::LINE_MAX)
				return 1'b0;
			kept_bytes++;
			collect_buf[collect_len] = c;
			collect_len++;
			collect_sum += c;
			if (c != calr_pkg::CH_LF && collect_len < calr_pkg::LINE_MAX)
				return 1'b1;

			total = collect_sum;
			case (link_phase)
				calr_pkg::PH_CONN: begin
					keep_line();
					retry_ctr  = 8'h00;
					link_phase = calr_pkg::PH_HELD;
					push_reply(KIND_TX, total, 1'b1, 8'h00);
					checksums++;
				end
				calr_pkg::PH_HELD: begin
					if (line_equals(ack_seq)) begin
						for (int i = 0; i < held_len; i++)
							push_reply(KIND_LINE, held_buf[i], i == held_len - 1, retry_ctr);
						if (retry_ctr > peak_retry)
							peak_retry = retry_ctr;
						link_phase = calr_pkg::PH_CONN;
						deliveries++;
					end else begin
						keep_line();
						if (retry_ctr != 8'hFF)
							retry_ctr++;
						push_reply(KIND_TX, total, 1'b1, 8'h00);
						checksums++;
					end
				end
				default: begin
					// anything but the connect request is thrown away here
					if (line_equals(conn_seq)) begin
						foreach (ack_seq[i])
							push_reply(KIND_TX, ack_seq[i], i == 3, 8'h00);
						link_phase = calr_pkg::PH_CONN;
						connects++;
					end
				end
			endcase
			collect_len = 0;
			collect_sum = 8'h00;
			return 1'b1;
		endfunction

		function void note_fault(string msg);
			faults++;
			if (faults <= 10)
				$display("%s", msg);
		endfunction

		// Compare one transferred reply with the oldest expectation
		function void match_reply(bit kind, bit [7:0] data, bit last, bit [7:0] rc);
			reply_t want;
			replies_seen++;
			if (expected_replies.size() == 0) begin
				note_fault($sformatf("unexpected reply: kind=%0d byte=%02h last=%0d retries=%0d",
					kind, data, last, rc));
				return;
			end
			want = expected_replies.pop_front();
			if (want.kind != kind || want.data != data || want.last != last ||
					want.retries != rc)
				note_fault($sformatf({"reply %0d mismatch: expected kind=%0d byte=%02h ",
					"last=%0d retries=%0d, got kind=%0d byte=%02h last=%0d retries=%0d"},
					replies_seen, want.kind, want.data, want.last, want.retries,
					kind, data, last, rc));
		endfunction

		function int waiting();
			return expected_replies.size();
		endfunction
	endclass

	line_reply_board board;

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: ends the run once nothing has transferred for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCH_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", WATCH_LIMIT);
		$display("[checksum_acked_line_receiver_unit] ERROR");
		$finish;
	end

	// Reply side: check each transfer, stall in short random bursts
	initial begin : reply_sink
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.match_reply(out_kind, out_byte, out_last, retry_count);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// One byte transfer; valid is kept high into the next byte unless a gap is taken
	task automatic send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		void'(board.take_byte(b));
		bytes_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] pick_char();
		int k;
		k = $urandom_range(0, 35);
		return (k < 10) ? CH_ZERO + 8'(k) : CH_A + 8'(k - 10);
	endfunction

	task automatic send_ack();
		send_byte(CH_O);
		send_byte(CH_K);
		send_byte(calr_pkg::CH_CR);
		send_byte(calr_pkg::CH_LF);
	endtask

	task automatic send_connect();
		send_byte(CH_K);
		send_byte(CH_O);
		send_byte(calr_pkg::CH_QM);
		send_byte(calr_pkg::CH_CR);
		send_byte(calr_pkg::CH_LF);
	endtask

	// Data line with random content, the odd CR or '?' inside and stray noise bytes
	task automatic send_data_line(input int len);
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 6) == 0)
				c = $urandom_range(0, 1) ? calr_pkg::CH_CR : calr_pkg::CH_QM;
			else
				c = pick_char();
			if ($urandom_range(0, 15) == 0)
				send_byte(8'($urandom_range(0, 255)));
			send_byte(c);
		end
		send_byte(calr_pkg::CH_LF);
	endtask

	// Line that fills the buffer, either without LF or with LF in the last slot
	task automatic send_full_line();
		int body;
		body = $urandom_range(0, 1) ? calr_pkg::LINE_MAX : calr_pkg::LINE_MAX - 1;
		for (int i = 0; i < body; i++)
			send_byte(pick_char());
		if (body < calr_pkg::LINE_MAX)
			send_byte(calr_pkg::CH_LF);
	endtask

	// Near misses of the acknowledge line
	task automatic send_broken_ack();
		case ($urandom_range(0, 3))
			0: begin
				send_byte(CH_O);
				send_byte(CH_K);
				send_byte(calr_pkg::CH_LF);
			end
			1: begin
				send_byte(CH_O);
				send_byte(CH_K);
				send_byte(calr_pkg::CH_CR);
				send_byte(calr_pkg::CH_CR);
				send_byte(calr_pkg::CH_LF);
			end
			2: begin
				send_byte(CH_X);
				send_ack();
			end
			default: begin
				send_byte(CH_O);
				send_byte(CH_K);
				send_byte(calr_pkg::CH_CR);
				send_byte(pick_char());
				send_byte(calr_pkg::CH_LF);
			end
		endcase
	endtask

	// Directed opening: dropped bytes, a discarded line, connect, ack as data, retry, delivery
	task automatic run_directed();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(calr_pkg::CH_LF);
		send_byte(calr_pkg::CH_QM);
		send_byte(calr_pkg::CH_CR);
		send_byte(CH_LOWA);
		send_byte("Z");
		send_byte("9");
		send_byte(calr_pkg::CH_LF);
		send_connect();
		send_ack();
		send_byte(CH_A);
		send_byte(calr_pkg::CH_LF);
		send_ack();
	endtask

	task automatic run_random();
		int pick;
		while (bytes_sent < ITEM_TARGET) begin
			if (bytes_sent > ITEM_TARGET - CALM_TAIL)
				idle_on = 1'b0;
			else if ($urandom_range(0, 7) == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_data_line($urandom_range(1, 12));
			end else if (pick < 62) begin
				send_ack();
			end else if (pick < 70) begin
				send_broken_ack();
			end else if (pick < 74) begin
				send_connect();
			end else if (pick < 78) begin
				send_full_line();
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				// bytes the filter refuses at the start of a line, then a real line
				case ($urandom_range(0, 3))
					0:       send_byte(calr_pkg::CH_CR);
					1:       send_byte(calr_pkg::CH_LF);
					2:       send_byte(calr_pkg::CH_QM);
					default: send_byte(CH_LOWA);
				endcase
				send_data_line($urandom_range(1, 6));
			end
		end
	endtask

	// Main sequence
	initial begin : stimulus
		board = new();
		bytes_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random();
		if (in_valid)
			in_valid <= 1'b0;

		while (board.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d bytes sent, %0d kept by the filter, %0d replies checked",
			bytes_sent, board.kept_bytes, board.replies_seen);
		$display("%0d connects, %0d checksums, %0d deliveries, top retry count %0d",
			board.connects, board.checksums, board.deliveries, board.peak_retry);
		if (board.faults == 0 && board.waiting() == 0) begin
			$display("[checksum_acked_line_receiver_unit] OK");
		end else begin
			$display("%0d mismatches, %0d replies outstanding", board.faults, board.waiting());
			$display("[checksum_acked_line_receiver_unit] ERROR");
		end
		$finish;
	end

endmodule
